[rtl/rsch_pkg.sv]
// Package for the ray / sphere closest-hit unit: widths, opcodes, sequencer
// states, multiply-accumulate phases and the stored sphere record.
// No dependencies.
package rsch_pkg;

    // Sphere table
    localparam int MAX_SPHERES = 16;
    localparam int IDX_W       = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNT_W       = $clog2(MAX_SPHERES + 1);

    // Fixed-point format and field widths
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int ENT_W     = 32;
    localparam int DIST_W    = 31;
    localparam int NRM_W     = 18;
    localparam int OC_W      = COORD_W + 1;

    // Shared multiplier: signed operands, products split at SPLIT_W bits
    localparam int SPLIT_W = 34;
    localparam int MUL_W   = SPLIT_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int HC_W    = 2 * SPLIT_W;
    localparam int ACC_W   = 2 * HC_W;
    localparam int A_W     = 2 * COORD_W;

    // Iterative square root and divider
    localparam int ROOT_W = ACC_W / 2;
    localparam int SREM_W = ROOT_W + 4;
    localparam int Q_W    = HC_W + FRAC_BITS;
    localparam int REM_W  = A_W + 1;
    localparam int ITER_W = $clog2(Q_W);
    localparam int STEP_W = 3;

    // Hit position sum before saturation
    localparam int POS_SUM_W = 2 * COORD_W - FRAC_BITS + 1;

    // Stream word layout
    localparam int IN_BITS  = 9 * COORD_W + RAD_W + ENT_W;
    localparam int S_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = DIST_W + 3 * COORD_W + 3 * NRM_W + ENT_W;
    localparam int M_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int S_USER_W = 2;
    localparam int M_USER_W = 2;

    localparam logic [Q_W-1:0] NRM_ONE = Q_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TRACE  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_ACC,
        ST_SQRT,
        ST_DIV,
        ST_BEST,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_A,
        PH_H,
        PH_C,
        PH_DISC,
        PH_POS,
        PH_LEN
    } phase_t;

    typedef enum logic [1:0] {
        SH_LOW,
        SH_MID,
        SH_TOP
    } shift_t;

    typedef struct packed {
        logic [ENT_W-1:0]          entity;
        logic [RAD_W-1:0]          radius;
        logic signed [COORD_W-1:0] cz;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cx;
    } sphere_t;

endpackage

[rtl/ray_sphere_closest_hit.sv]
// Ray / sphere closest-hit unit: sphere table, sequencer and the shared
// multiply-accumulate, square root and divide datapath.
// Depends on rsch_pkg.
//
// Clear, append and no-operation words are answered from the idle state. A trace word walks
// the sphere table through one shared 35 x 35 multiplier with a 136-bit
// accumulator, a radix-2 square root (68 steps) and a restoring divider
// (84 steps). A sphere ruled out by the signs of h and c skips the discriminant,
// square root and divider; one ruled out by a negative discriminant skips the
// square root and divider; and a trace that misses everything skips the hit
// position and normal. The input is not ready while a trace is running
// or while a finished result still waits at the output.
module ray_sphere_closest_hit
    import rsch_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Input word.
    input  logic                s_tvalid,
    output logic                s_tready,
    // center_x, center_y, center_z, sphere_radius, sphere_entity,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // opcode
    input  logic [S_USER_W-1:0] s_tuser,
    // Result word.
    output logic                m_tvalid,
    input  logic                m_tready,
    // hit_distance, hit_pos_x, hit_pos_y, hit_pos_z, normal_x, normal_y,
    // normal_z, hit_entity, zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    // hit, table_full
    output logic [M_USER_W-1:0] m_tuser
);

    // Control registers
    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [1:0]          comp_reg, comp_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    logic                sq_norm_reg, sq_norm_next;
    logic                dv_norm_reg, dv_norm_next;
    logic                m_valid_reg, m_valid_next;

    // Payload registers
    logic signed [COORD_W-1:0] o_reg [3];
    logic signed [COORD_W-1:0] o_next [3];
    logic signed [COORD_W-1:0] d_reg [3];
    logic signed [COORD_W-1:0] d_next [3];
    logic signed [COORD_W-1:0] pos_reg [3];
    logic signed [COORD_W-1:0] pos_next [3];
    logic signed [NRM_W-1:0]   nrm_reg [3];
    logic signed [NRM_W-1:0]   nrm_next [3];
    logic [A_W-1:0]            a_reg, a_next;
    logic signed [HC_W-1:0]    h_reg, h_next;
    logic [HC_W-1:0]           c_reg, c_next;
    logic [HC_W-1:0]           hmag_reg, hmag_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [ACC_W-1:0]          rad_reg, rad_next;
    logic [ROOT_W-1:0]         root_reg, root_next;
    logic [SREM_W-1:0]         srem_reg, srem_next;
    logic [Q_W-1:0]            nq_reg, nq_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [A_W-1:0]            dvs_reg, dvs_next;
    logic [Q_W-1:0]            best_q_reg, best_q_next;
    logic [IDX_W-1:0]          best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]         t_reg, t_next;
    logic [M_DATA_W-1:0]       m_data_reg, m_data_next;
    logic [M_USER_W-1:0]       m_user_reg, m_user_next;

    // Sphere table and its registered read port
    sphere_t sph_mem [MAX_SPHERES];
    sphere_t sph_reg;
    sphere_t in_sphere;

    // Handshake and decode
    op_t  in_op;
    logic accept;
    logic out_free;
    logic table_is_full;

    // Datapath signals
    logic signed [COORD_W-1:0] cen [3];
    logic signed [MUL_W-1:0]   d_m [3];
    logic signed [MUL_W-1:0]   oc_m [3];
    logic signed [MUL_W-1:0]   diff_m [3];
    logic signed [OC_W-1:0]    diff [3];
    logic [OC_W-1:0]           diff_mag [3];
    logic [1:0]                ax;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    shift_t                    term_sh;
    logic                      term_sub;
    logic [STEP_W-1:0]         last_step;
    logic                      mac_last;
    logic signed [ACC_W-1:0]   term_ext, term_shifted, acc_sum;
    logic signed [PROD_W-1:0]  prod_scaled;
    logic signed [POS_SUM_W-1:0] pos_sum;
    logic signed [COORD_W-1:0] pos_sat;
    logic                      c_pos, len_zero, a_zero;
    logic [SREM_W-1:0]         srem_sh, trial, srem_step;
    logic                      sq_ge, sq_last;
    logic [ROOT_W-1:0]         root_step;
    logic [REM_W-1:0]          rem_sh, rem_step;
    logic                      dv_ge, dv_last;
    logic [Q_W-1:0]            nq_step, nq_clamp;
    logic [NRM_W-1:0]          nrm_mag;
    logic                      last_sphere;
    logic                      q_better;

    // Input field decode
    assign in_op            = op_t'(s_tuser);
    assign in_sphere.cx     = s_tdata[0 +: COORD_W];
    assign in_sphere.cy     = s_tdata[COORD_W +: COORD_W];
    assign in_sphere.cz     = s_tdata[2*COORD_W +: COORD_W];
    assign in_sphere.radius = s_tdata[3*COORD_W +: RAD_W];
    assign in_sphere.entity = s_tdata[3*COORD_W+RAD_W +: ENT_W];

    assign out_free      = !m_valid_reg || m_tready;
    assign s_tready      = (state_reg == ST_IDLE) && out_free;
    assign accept        = s_tvalid && s_tready;
    assign table_is_full = (cnt_reg == CNT_W'(MAX_SPHERES));

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Per-axis operands for the multiplier
    assign cen[0] = sph_reg.cx;
    assign cen[1] = sph_reg.cy;
    assign cen[2] = sph_reg.cz;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_m[k]      = MUL_W'(d_reg[k]);
            oc_m[k]     = MUL_W'(OC_W'(o_reg[k]) - OC_W'(cen[k]));
            diff[k]     = OC_W'(pos_reg[k]) - OC_W'(cen[k]);
            diff_m[k]   = MUL_W'(diff[k]);
            diff_mag[k] = diff[k][OC_W-1] ? OC_W'(-diff[k]) : OC_W'(diff[k]);
        end
    end

    assign ax = step_reg[1:0];

    // Term selection for the shared multiply-accumulate
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        term_sh   = SH_LOW;
        term_sub  = 1'b0;
        last_step = STEP_W'(2);
        unique case (phase_reg)
            PH_A:
            begin
                mul_a = d_m[ax];
                mul_b = d_m[ax];
            end
            PH_H:
            begin
                mul_a = oc_m[ax];
                mul_b = d_m[ax];
            end
            PH_C:
            begin
                last_step = STEP_W'(3);
                if (step_reg == STEP_W'(3))
                begin
                    mul_a    = MUL_W'(sph_reg.radius);
                    mul_b    = MUL_W'(sph_reg.radius);
                    term_sub = 1'b1;
                end
                else
                begin
                    mul_a = oc_m[ax];
                    mul_b = oc_m[ax];
                end
            end
            PH_DISC:
            begin
                // |h|^2 - a*c from 34-bit pieces.
                last_step = STEP_W'(7);
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'({1'b0, hmag_reg[SPLIT_W-1:0]});
                        mul_b = MUL_W'({1'b0, hmag_reg[SPLIT_W-1:0]});
                    end
                    3'd1, 3'd2:
                    begin
                        mul_a   = MUL_W'({1'b0, hmag_reg[SPLIT_W-1:0]});
                        mul_b   = MUL_W'({1'b0, hmag_reg[HC_W-1:SPLIT_W]});
                        term_sh = SH_MID;
                    end
                    3'd3:
                    begin
                        mul_a   = MUL_W'({1'b0, hmag_reg[HC_W-1:SPLIT_W]});
                        mul_b   = MUL_W'({1'b0, hmag_reg[HC_W-1:SPLIT_W]});
                        term_sh = SH_TOP;
                    end
                    3'd4:
                    begin
                        mul_a    = MUL_W'({1'b0, a_reg[SPLIT_W-1:0]});
                        mul_b    = MUL_W'({1'b0, c_reg[SPLIT_W-1:0]});
                        term_sub = 1'b1;
                    end
                    3'd5:
                    begin
                        mul_a    = MUL_W'({1'b0, a_reg[SPLIT_W-1:0]});
                        mul_b    = MUL_W'({1'b0, c_reg[HC_W-1:SPLIT_W]});
                        term_sh  = SH_MID;
                        term_sub = 1'b1;
                    end
                    3'd6:
                    begin
                        mul_a    = MUL_W'({1'b0, SPLIT_W'(a_reg[A_W-1:SPLIT_W])});
                        mul_b    = MUL_W'({1'b0, c_reg[SPLIT_W-1:0]});
                        term_sh  = SH_MID;
                        term_sub = 1'b1;
                    end
                    default:
                    begin
                        mul_a    = MUL_W'({1'b0, SPLIT_W'(a_reg[A_W-1:SPLIT_W])});
                        mul_b    = MUL_W'({1'b0, c_reg[HC_W-1:SPLIT_W]});
                        term_sh  = SH_TOP;
                        term_sub = 1'b1;
                    end
                endcase
            end
            PH_POS:
            begin
                mul_a = d_m[ax];
                mul_b = MUL_W'(t_reg);
            end
            PH_LEN:
            begin
                mul_a = diff_m[ax];
                mul_b = diff_m[ax];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mac_last  = (step_reg == last_step);
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Accumulator update with the selected weight
    assign term_ext = ACC_W'(prod_reg);
    always_comb
    begin
        case (term_sh)
            SH_MID:  term_shifted = term_ext <<< SPLIT_W;
            SH_TOP:  term_shifted = term_ext <<< HC_W;
            default: term_shifted = term_ext;
        endcase
    end
    assign acc_sum  = term_sub ? (acc_reg - term_shifted) : (acc_reg + term_shifted);
    assign a_zero   = (acc_sum == '0);
    assign len_zero = (acc_sum == '0);
    assign c_pos    = !acc_sum[ACC_W-1] && (acc_sum != '0);

    // Hit position: origin plus floor(D * T / 2^FRAC_BITS), saturated
    assign prod_scaled = prod_reg >>> FRAC_BITS;
    assign pos_sum     = POS_SUM_W'(o_reg[ax]) + POS_SUM_W'(prod_scaled);
    always_comb
    begin
        if (pos_sum > POS_SUM_W'(32'sh7FFFFFFF))
            pos_sat = 32'sh7FFFFFFF;
        else if (pos_sum < -POS_SUM_W'(33'sh080000000))
            pos_sat = 32'sh80000000;
        else
            pos_sat = COORD_W'(pos_sum);
    end

    // Square root step: two radicand bits per cycle
    assign srem_sh   = {srem_reg[SREM_W-3:0], rad_reg[ACC_W-1 -: 2]};
    assign trial     = SREM_W'({root_reg, 2'b01});
    assign sq_ge     = (srem_sh >= trial);
    assign srem_step = sq_ge ? (srem_sh - trial) : srem_sh;
    assign root_step = {root_reg[ROOT_W-2:0], sq_ge};
    assign sq_last   = (iter_reg == ITER_W'(ROOT_W - 1));

    // Restoring divide step: one quotient bit per cycle
    assign rem_sh   = {rem_reg[REM_W-2:0], nq_reg[Q_W-1]};
    assign dv_ge    = (rem_sh >= REM_W'(dvs_reg));
    assign rem_step = dv_ge ? (rem_sh - REM_W'(dvs_reg)) : rem_sh;
    assign nq_step  = {nq_reg[Q_W-2:0], dv_ge};
    assign dv_last  = (iter_reg == ITER_W'(Q_W - 1));
    assign nq_clamp = (nq_step > NRM_ONE) ? NRM_ONE : nq_step;
    assign nrm_mag  = NRM_W'(nq_clamp);

    assign last_sphere = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    assign q_better    = !found_reg || (nq_reg < best_q_reg);

    // Next-state logic of the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_op == OP_TRACE)
                    state_next = ST_MUL;
            end
            ST_FETCH:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
            begin
                if (!mac_last)
                    state_next = ST_MUL;
                else
                begin
                    unique case (phase_reg)
                        PH_A:    state_next = (a_zero || cnt_reg == '0) ? ST_DONE : ST_FETCH;
                        PH_H:    state_next = ST_MUL;
                        PH_C:    state_next = (h_reg[HC_W-1] && c_pos) ? ST_MUL : ST_NEXT;
                        PH_DISC: state_next = acc_sum[ACC_W-1] ? ST_NEXT : ST_SQRT;
                        PH_POS:  state_next = ST_MUL;
                        PH_LEN:  state_next = len_zero ? ST_DONE : ST_SQRT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SQRT:
            begin
                if (sq_last)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dv_last)
                begin
                    if (!dv_norm_reg)
                        state_next = ST_BEST;
                    else if (comp_reg == 2'd2)
                        state_next = ST_DONE;
                end
            end
            ST_BEST:
                state_next = ST_NEXT;
            ST_NEXT:
            begin
                if (!last_sphere)
                    state_next = ST_FETCH;
                else if (found_reg)
                    state_next = ST_MUL;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and output updates of the sequencer
    always_comb
    begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        iter_next     = iter_reg;
        comp_next     = comp_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        sq_norm_next  = sq_norm_reg;
        dv_norm_next  = dv_norm_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_next        = o_reg;
        d_next        = d_reg;
        pos_next      = pos_reg;
        nrm_next      = nrm_reg;
        a_next        = a_reg;
        h_next        = h_reg;
        c_next        = c_reg;
        hmag_next     = hmag_reg;
        acc_next      = acc_reg;
        rad_next      = rad_reg;
        root_next     = root_reg;
        srem_next     = srem_reg;
        nq_next       = nq_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        best_q_next   = best_q_reg;
        best_idx_next = best_idx_reg;
        t_next        = t_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_CLEAR:
                        begin
                            cnt_next     = '0;
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                            m_user_next  = '0;
                        end
                        OP_APPEND:
                        begin
                            if (!table_is_full)
                                cnt_next = cnt_reg + CNT_W'(1);
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                            m_user_next  = {table_is_full, 1'b0};
                        end
                        OP_TRACE:
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                o_next[k]   = s_tdata[(3+k)*COORD_W+RAD_W+ENT_W +: COORD_W];
                                d_next[k]   = s_tdata[(6+k)*COORD_W+RAD_W+ENT_W +: COORD_W];
                                nrm_next[k] = '0;
                            end
                            found_next = 1'b0;
                            phase_next = PH_A;
                            step_next  = '0;
                            acc_next   = '0;
                        end
                        OP_NOP:
                        begin
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                            m_user_next  = '0;
                        end
                        default:
                        begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                phase_next = PH_H;
                step_next  = '0;
                acc_next   = '0;
            end
            ST_ACC:
            begin
                acc_next = acc_sum;
                if (phase_reg == PH_POS)
                    pos_next[ax] = pos_sat;
                if (!mac_last)
                    step_next = step_reg + STEP_W'(1);
                else
                begin
                    step_next = '0;
                    unique case (phase_reg)
                        PH_A:
                        begin
                            a_next   = acc_sum[A_W-1:0];
                            idx_next = '0;
                        end
                        PH_H:
                        begin
                            h_next     = acc_sum[HC_W-1:0];
                            phase_next = PH_C;
                            acc_next   = '0;
                        end
                        PH_C:
                        begin
                            c_next     = acc_sum[HC_W-1:0];
                            hmag_next  = HC_W'(-h_reg);
                            phase_next = PH_DISC;
                            acc_next   = '0;
                        end
                        PH_DISC:
                        begin
                            rad_next     = acc_sum;
                            root_next    = '0;
                            srem_next    = '0;
                            iter_next    = '0;
                            sq_norm_next = 1'b0;
                        end
                        PH_POS:
                        begin
                            phase_next = PH_LEN;
                            acc_next   = '0;
                        end
                        PH_LEN:
                        begin
                            rad_next     = acc_sum << (2 * FRAC_BITS);
                            root_next    = '0;
                            srem_next    = '0;
                            iter_next    = '0;
                            sq_norm_next = 1'b1;
                        end
                        default:
                        begin
                            acc_next = '0;
                        end
                    endcase
                end
            end
            ST_SQRT:
            begin
                srem_next = srem_step;
                root_next = root_step;
                rad_next  = rad_reg << 2;
                iter_next = iter_reg + ITER_W'(1);
                if (sq_last)
                begin
                    // Hand the root to the divider.
                    iter_next = '0;
                    rem_next  = '0;
                    if (!sq_norm_reg)
                    begin
                        nq_next      = Q_W'(hmag_reg - root_step) << FRAC_BITS;
                        dvs_next     = a_reg;
                        dv_norm_next = 1'b0;
                    end
                    else
                    begin
                        nq_next      = Q_W'(diff_mag[0]) << (2 * FRAC_BITS);
                        dvs_next     = A_W'(root_step);
                        dv_norm_next = 1'b1;
                        comp_next    = '0;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_step;
                nq_next   = nq_step;
                iter_next = iter_reg + ITER_W'(1);
                if (dv_last)
                begin
                    iter_next = '0;
                    if (dv_norm_reg)
                    begin
                        nrm_next[comp_reg] = diff[comp_reg][OC_W-1] ?
                                             NRM_W'(-nrm_mag) : nrm_mag;
                        comp_next = comp_reg + 2'd1;
                        if (comp_reg != 2'd2)
                        begin
                            rem_next = '0;
                            nq_next  = Q_W'(diff_mag[comp_reg + 2'd1]) << (2 * FRAC_BITS);
                        end
                    end
                end
            end
            ST_BEST:
            begin
                // Strictly smaller only, so the earliest sphere wins a tie.
                if (q_better)
                begin
                    best_q_next   = nq_reg;
                    best_idx_next = idx_reg;
                    found_next    = 1'b1;
                end
            end
            ST_NEXT:
            begin
                if (!last_sphere)
                    idx_next = idx_reg + IDX_W'(1);
                else if (found_reg)
                begin
                    idx_next   = best_idx_reg;
                    phase_next = PH_POS;
                    step_next  = '0;
                    t_next     = (|best_q_reg[Q_W-1:DIST_W]) ? '1 : best_q_reg[DIST_W-1:0];
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = {1'b0, found_reg};
                    if (found_reg)
                        m_data_next = M_DATA_W'({sph_reg.entity,
                                                 nrm_reg[2], nrm_reg[1], nrm_reg[0],
                                                 pos_reg[2], pos_reg[1], pos_reg[0],
                                                 t_reg});
                    else
                        m_data_next = '0;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_A;
            step_reg    <= '0;
            iter_reg    <= '0;
            comp_reg    <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            sq_norm_reg <= 1'b0;
            dv_norm_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            iter_reg    <= iter_next;
            comp_reg    <= comp_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            found_reg   <= found_next;
            sq_norm_reg <= sq_norm_next;
            dv_norm_reg <= dv_norm_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        o_reg        <= o_next;
        d_reg        <= d_next;
        pos_reg      <= pos_next;
        nrm_reg      <= nrm_next;
        a_reg        <= a_next;
        h_reg        <= h_next;
        c_reg        <= c_next;
        hmag_reg     <= hmag_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        rad_reg      <= rad_next;
        root_reg     <= root_next;
        srem_reg     <= srem_next;
        nq_reg       <= nq_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        best_q_reg   <= best_q_next;
        best_idx_reg <= best_idx_next;
        t_reg        <= t_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    // Sphere table: append writes at the fill count, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && in_op == OP_APPEND && !table_is_full)
            sph_mem[cnt_reg[IDX_W-1:0]] <= in_sphere;
        sph_reg <= sph_mem[idx_reg];
    end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the ray / sphere closest-hit unit.
// Drives clear, append, trace and no-op words, predicts each result word in a
// wide-integer model of its own and compares it as a whole, printing each field on a mismatch. Needs rsch_pkg.
`timescale 1ns / 100ps

module testbench;
    import rsch_pkg::*;

    localparam int    HALF_PERIOD = 6;
    localparam int    STALL_LIMIT = 20000;
    localparam int    DRAIN_WAIT  = 4000;
    localparam int    NUM_ITEMS   = 1550;
    localparam int    ONE         = 1 << FRAC_BITS;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        op_t                       op;
        logic signed [COORD_W-1:0] cx, cy, cz;
        logic [RAD_W-1:0]          rad;
        logic [ENT_W-1:0]          ent;
        logic signed [COORD_W-1:0] ox, oy, oz, dx, dy, dz;
    } ray_word_t;

    typedef struct packed {
        logic                      hit;
        logic                      full;
        logic [DIST_W-1:0]         distance;
        logic signed [COORD_W-1:0] px, py, pz;
        logic signed [NRM_W-1:0]   nx, ny, nz;
        logic [ENT_W-1:0]          ent;
    } hit_word_t;

    typedef struct packed {
        ray_word_t word;
        int        reps;
        logic      known;
        hit_word_t result;
    } stim_row_t;

    localparam hit_word_t NO_HIT    = '0;
    localparam hit_word_t FULL_DROP = '{full: 1'b1, default: '0};

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    // Predictor copy of the sphere table.
    logic signed [COORD_W-1:0] tbl_cx [MAX_SPHERES];
    logic signed [COORD_W-1:0] tbl_cy [MAX_SPHERES];
    logic signed [COORD_W-1:0] tbl_cz [MAX_SPHERES];
    logic [RAD_W-1:0]          tbl_rad [MAX_SPHERES];
    logic [ENT_W-1:0]          tbl_ent [MAX_SPHERES];
    int                        tbl_count = 0;

    hit_word_t pending_hits [$];
    int        error_count  = 0;
    int        traces_sent  = 0;
    int        hits_seen    = 0;
    int        drops_seen   = 0;
    int        idle_cycles  = 0;
    bit        no_gaps      = 1'b0;
    bit        long_hold    = 1'b0;

    ray_sphere_closest_hit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // Integer square root, floor, for values below 2^190.
    function automatic wide_t isqrt(wide_t x);
        wide_t root;
        wide_t cand;
        root = '0;
        for (int i = 95; i >= 0; i--)
        begin
            cand = root | (wide_t'(1) <<< i);
            if (cand * cand <= x)
                root = cand;
        end
        return root;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Nearest sphere hit for one ray, or all zero on a miss.
    function automatic hit_word_t nearest_hit(ray_word_t w);
        hit_word_t r;
        wide_t     a, h, c, disc, q, best, len2, len, nq;
        wide_t     oc [3];
        wide_t     d [3];
        longint    pos [3];
        longint    diff [3];
        longint    org [3];
        longint    tsat;
        longint    mag;
        int        best_idx;
        r = NO_HIT;
        best_idx = -1;
        best = '0;
        org[0] = w.ox;
        org[1] = w.oy;
        org[2] = w.oz;
        d[0] = wide_t'(w.dx);
        d[1] = wide_t'(w.dy);
        d[2] = wide_t'(w.dz);
        a = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        if (a == 0)
            return r;
        for (int i = 0; i < tbl_count; i++)
        begin
            oc[0] = wide_t'(w.ox) - wide_t'(tbl_cx[i]);
            oc[1] = wide_t'(w.oy) - wide_t'(tbl_cy[i]);
            oc[2] = wide_t'(w.oz) - wide_t'(tbl_cz[i]);
            h = oc[0] * d[0] + oc[1] * d[1] + oc[2] * d[2];
            c = oc[0] * oc[0] + oc[1] * oc[1] + oc[2] * oc[2]
                - wide_t'(tbl_rad[i]) * wide_t'(tbl_rad[i]);
            if (h >= 0 || c <= 0)
                continue;
            disc = h * h - a * c;
            if (disc < 0)
                continue;
            q = ((-h - isqrt(disc)) <<< FRAC_BITS) / a;
            if (best_idx < 0 || q < best)
            begin
                best = q;
                best_idx = i;
            end
        end
        if (best_idx < 0)
            return r;
        tsat = (best > 64'sd2147483647) ? 64'sd2147483647 : longint'(best);
        for (int k = 0; k < 3; k++)
            pos[k] = clamp32(org[k] + ((longint'(d[k]) * tsat) >>> FRAC_BITS));
        r.hit = 1'b1;
        r.distance = tsat[DIST_W-1:0];
        r.px = pos[0][31:0];
        r.py = pos[1][31:0];
        r.pz = pos[2][31:0];
        diff[0] = pos[0] - longint'(tbl_cx[best_idx]);
        diff[1] = pos[1] - longint'(tbl_cy[best_idx]);
        diff[2] = pos[2] - longint'(tbl_cz[best_idx]);
        len2 = wide_t'(diff[0]) * diff[0] + wide_t'(diff[1]) * diff[1]
               + wide_t'(diff[2]) * diff[2];
        if (len2 != 0)
        begin
            len = isqrt(len2 <<< (2 * FRAC_BITS));
            for (int k = 0; k < 3; k++)
            begin
                mag = (diff[k] < 0) ? -diff[k] : diff[k];
                nq = (wide_t'(mag) <<< (2 * FRAC_BITS)) / len;
                if (nq > ONE)
                    nq = ONE;
                mag = (diff[k] < 0) ? -longint'(nq) : longint'(nq);
                if (k == 0) r.nx = mag[NRM_W-1:0];
                if (k == 1) r.ny = mag[NRM_W-1:0];
                if (k == 2) r.nz = mag[NRM_W-1:0];
            end
        end
        r.ent = tbl_ent[best_idx];
        return r;
    endfunction

    // Applies one accepted word to the table copy and returns its result.
    function automatic hit_word_t apply_word(ray_word_t w);
        hit_word_t r;
        r = NO_HIT;
        case (w.op)
            OP_CLEAR:
                tbl_count = 0;
            OP_APPEND:
            begin
                if (tbl_count < MAX_SPHERES)
                begin
                    tbl_cx[tbl_count] = w.cx;
                    tbl_cy[tbl_count] = w.cy;
                    tbl_cz[tbl_count] = w.cz;
                    tbl_rad[tbl_count] = w.rad;
                    tbl_ent[tbl_count] = w.ent;
                    tbl_count++;
                end
                else
                begin
                    r = FULL_DROP;
                end
            end
            OP_TRACE:
                r = nearest_hit(w);
            default:
                r = NO_HIT;
        endcase
        return r;
    endfunction

    // Offers one word, waits for it to be taken, then queues its result.
    task automatic send_word(ray_word_t w, logic known, hit_word_t typed);
        int        gap;
        hit_word_t predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.op;
        s_tdata <= S_DATA_W'({w.dz, w.dy, w.dx, w.oz, w.oy, w.ox,
                              w.ent, w.rad, w.cz, w.cy, w.cx});
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_word(w);
        if (w.op == OP_TRACE)
            traces_sent++;
        pending_hits.push_back(known ? typed : predicted);
        @(negedge clk);
    endtask

    function automatic ray_word_t noise_word();
        ray_word_t w;
        w.op = op_t'($urandom_range(0, 3));
        w.cx = $urandom;
        w.cy = $urandom;
        w.cz = $urandom;
        w.rad = $urandom;
        w.ent = $urandom;
        w.ox = $urandom;
        w.oy = $urandom;
        w.oz = $urandom;
        w.dx = $urandom;
        w.dy = $urandom;
        w.dz = $urandom;
        return w;
    endfunction

    function automatic logic signed [COORD_W-1:0] spread(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // A sphere in a box of about +-128 units, radius up to 16 units.
    function automatic ray_word_t scene_sphere();
        ray_word_t w;
        w = noise_word();
        w.op = OP_APPEND;
        w.cx = spread(1 << 23);
        w.cy = spread(1 << 23);
        w.cz = spread(1 << 23);
        w.rad = $urandom_range(1 << 12, 1 << 20);
        return w;
    endfunction

    // A ray aimed near one stored sphere, from outside or inside it.
    function automatic ray_word_t aimed_ray();
        ray_word_t w;
        int        idx;
        int        jit;
        w = noise_word();
        w.op = OP_TRACE;
        if (tbl_count == 0)
            return w;
        idx = $urandom_range(0, tbl_count - 1);
        jit = $urandom_range(1, 1 << 20);
        w.ox = tbl_cx[idx] + spread(1 << 22);
        w.oy = tbl_cy[idx] + spread(1 << 22);
        w.oz = tbl_cz[idx] + spread(1 << 22);
        w.dx = (tbl_cx[idx] - w.ox + spread(jit)) >>> $urandom_range(0, 8);
        w.dy = (tbl_cy[idx] - w.oy + spread(jit)) >>> $urandom_range(0, 8);
        w.dz = (tbl_cz[idx] - w.oz + spread(jit)) >>> $urandom_range(0, 8);
        return w;
    endfunction

    // Result side: random back-pressure, one long hold when asked.
    initial
    begin : result_side
        hit_word_t got;
        hit_word_t want;
        int        stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (long_hold)
            begin
                stall = 400;
                long_hold = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.hit = m_tuser[0];
            got.full = m_tuser[1];
            got.distance = m_tdata[30:0];
            got.px = m_tdata[62:31];
            got.py = m_tdata[94:63];
            got.pz = m_tdata[126:95];
            got.nx = m_tdata[144:127];
            got.ny = m_tdata[162:145];
            got.nz = m_tdata[180:163];
            got.ent = m_tdata[212:181];
            if (got.hit)
                hits_seen++;
            if (got.full)
                drops_seen++;
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: mismatch hit exp %0d got %0d, full exp %0d got %0d",
                             $time, want.hit, got.hit, want.full, got.full);
                    $display("    distance exp %0d got %0d, ent exp %h got %h",
                             want.distance, got.distance, want.ent, got.ent);
                    $display("    pos exp %0d %0d %0d got %0d %0d %0d",
                             want.px, want.py, want.pz, got.px, got.py, got.pz);
                    $display("    normal exp %0d %0d %0d got %0d %0d %0d",
                             want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("[ray_sphere_closest_hit] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t rows [$];
        ray_word_t w;
        int        sent;
        int        spheres;
        int        rays;

        // Directed rows: empty table, a hit at distance nine, inside, on the surface,
        // behind, zero direction, tie, extremes, saturated distance, full table.
        rows = '{
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_APPEND, 10 * ONE, 0, 0, ONE, 32'ha5a5a5a5, 0, 0, 0, 0, 0, 0},
              1, 1'b1, NO_HIT},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0}, 1, 1'b1,
              '{1'b1, 1'b0, 9 * ONE, 9 * ONE, 0, 0, -ONE, 0, 0, 32'ha5a5a5a5}},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 10 * ONE, 0, 0, ONE, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 9 * ONE, 0, 0, ONE, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 0, 0, 0, -ONE, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_APPEND, 10 * ONE, 0, 0, ONE, 2, 0, 0, 0, 0, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0}, 1, 1'b1,
              '{1'b1, 1'b0, 9 * ONE, 9 * ONE, 0, 0, -ONE, 0, 0, 32'ha5a5a5a5}},
            '{'{OP_NOP, -1, -1, -1, '1, '1, -1, -1, -1, -1, -1, -1}, 1, 1'b1, NO_HIT},
            '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_APPEND, 32'sh80000000, 32'sh80000000, 32'sh80000000, '1, '1,
                0, 0, 0, 0, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_APPEND, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0,
                0, 0, 0, 0, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 1, 1'b0, NO_HIT},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                32'sh80000000, 32'sh80000000, 32'sh80000000}, 1, 1'b0, NO_HIT},
            '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_APPEND, 1000 * ONE, 0, 0, ONE, 7, 0, 0, 0, 0, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0}, 1, 1'b0, NO_HIT},
            '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1'b1, NO_HIT},
            '{'{OP_APPEND, 0, 20 * ONE, 0, 2 * ONE, 3, 0, 0, 0, 0, 0, 0}, 16, 1'b1, NO_HIT},
            '{'{OP_APPEND, 0, 0, 0, ONE, 4, 0, 0, 0, 0, 0, 0}, 1, 1'b1, FULL_DROP},
            '{'{OP_TRACE, 0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0}, 1, 1'b0, NO_HIT},
            '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1'b1, NO_HIT}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        sent = 0;
        foreach (rows[i])
        begin
            for (int r = 0; r < rows[i].reps; r++)
            begin
                send_word(rows[i].word, rows[i].known, rows[i].result);
                sent++;
            end
        end

        // Random scenes: a few spheres, then rays aimed at them, with noise.
        while (sent < NUM_ITEMS)
        begin
            if (sent > 300 && sent < 320)
                no_gaps = 1'b1;
            else
                no_gaps = 1'b0;
            if (sent > 600 && sent < 610)
                long_hold = 1'b1;
            if ($urandom_range(0, 3) != 0)
            begin
                w = noise_word();
                w.op = OP_CLEAR;
                send_word(w, 1'b0, NO_HIT);
                sent++;
            end
            spheres = ($urandom_range(0, 19) == 0) ? 17 : $urandom_range(1, 3);
            for (int s = 0; s < spheres; s++)
            begin
                send_word(scene_sphere(), 1'b0, NO_HIT);
                sent++;
            end
            rays = $urandom_range(2, 8);
            for (int t = 0; t < rays; t++)
            begin
                w = ($urandom_range(0, 7) == 0) ? noise_word() : aimed_ray();
                send_word(w, 1'b0, NO_HIT);
                sent++;
            end
            // Let the pipeline drain completely once in a while.
            if ($urandom_range(0, 15) == 0)
            begin
                s_tvalid <= 1'b0;
                wait (pending_hits.size() == 0);
                @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;

        wait (pending_hits.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Sent %0d words with %0d traces; %0d hits and %0d full-table drops seen.",
                 sent, traces_sent, hits_seen, drops_seen);
        if (error_count == 0 && pending_hits.size() == 0)
            $display("[ray_sphere_closest_hit] OK");
        else
            $display("[ray_sphere_closest_hit] ERROR");
        $finish;
    end

endmodule
